FILE: rtl/core/sdim_pkg.sv
// shared constants and types for the signed divide-by-invariant block
package sdim_pkg;

  localparam int DATA_WIDTH_DEF = 32;  // default arithmetic width
  localparam int TDATA_W        = 32;  // dividend, quotient and divisor port width
  localparam int SHIFT_W        = 5;   // post-shift field width

  // status handed from the magic unit to the quotient datapath
  typedef struct packed {
    logic busy;         // magic computation in progress
    logic magic_valid;  // divisor is nonzero
    logic div_neg;      // divisor is negative
  } sdim_status_t;

endpackage

FILE: rtl/core/sdim_magic.sv
// magic multiplier and post-shift unit, iterative shift and restoring divide
module sdim_magic import sdim_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [TDATA_W-1:0]    cfg_wdata,
  output logic [DATA_WIDTH-1:0] magic_o,
  output logic [SHIFT_W-1:0]    shift_o,
  output sdim_status_t          status_o
);

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(W);

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_ABS   = 3'd1;
  localparam logic [2:0] M_PREP  = 3'd2;
  localparam logic [2:0] M_SHIFT = 3'd3;
  localparam logic [2:0] M_DIV   = 3'd4;
  localparam logic [2:0] M_DONE  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [W-1:0]       d_r, d_nxt;
  logic [W-1:0]       ad_r, ad_nxt;
  logic [W-1:0]       t_r, t_nxt;
  logic [W-1:0]       rem_r, rem_nxt;
  logic [W-1:0]       q_r, q_nxt;
  logic [SHIFT_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [W-1:0]       m_r, m_nxt;
  logic [SHIFT_W-1:0] shout_r, shout_nxt;
  logic               valid_r, valid_nxt;
  logic               neg_r, neg_nxt;

  logic [W:0]         r2;
  logic [W:0]         diff;

  assign r2   = {rem_r, 1'b0};
  assign diff = r2 - {1'b0, ad_r};

  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    ad_nxt    = ad_r;
    t_nxt     = t_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    m_nxt     = m_r;
    shout_nxt = shout_r;
    valid_nxt = valid_r;
    neg_nxt   = neg_r;
    case (state_r)
      M_IDLE: ;
      M_ABS: begin
        if (d_r == '0) begin
          valid_nxt = 1'b0;
          m_nxt     = '0;
          shout_nxt = '0;
          state_nxt = M_IDLE;
        end else begin
          ad_nxt    = d_r[W-1] ? (~d_r + 1'b1) : d_r;
          state_nxt = M_PREP;
        end
      end
      M_PREP: begin
        if (ad_r == W'(1)) begin
          // divisor of plus or minus one
          m_nxt     = W'(1);
          shout_nxt = '0;
          valid_nxt = 1'b1;
          neg_nxt   = d_r[W-1];
          state_nxt = M_IDLE;
        end else begin
          t_nxt     = (ad_r - 1'b1) >> 1;
          sh_nxt    = '0;
          rem_nxt   = W'(1);
          state_nxt = M_SHIFT;
        end
      end
      M_SHIFT: begin
        if (t_r != '0) begin
          t_nxt   = t_r >> 1;
          sh_nxt  = sh_r + 1'b1;
          rem_nxt = rem_r << 1;  // tracks 2^sh
        end else begin
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = M_DIV;
        end
      end
      M_DIV: begin
        // one quotient bit of 2^(W+sh) / |d| per cycle
        if (!diff[W]) begin
          rem_nxt = diff[W-1:0];
          q_nxt   = {q_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = r2[W-1:0];
          q_nxt   = {q_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W-1)) begin
          state_nxt = M_DONE;
        end
      end
      M_DONE: begin
        m_nxt     = q_r + 1'b1;
        shout_nxt = sh_r;
        valid_nxt = 1'b1;
        neg_nxt   = d_r[W-1];
        state_nxt = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
    if (cfg_wen) begin
      d_nxt     = cfg_wdata[W-1:0];
      state_nxt = M_ABS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      m_r     <= W'(1);
      shout_r <= '0;
      valid_r <= 1'b1;
      neg_r   <= 1'b0;
      d_r     <= W'(1);
    end else begin
      state_r <= state_nxt;
      m_r     <= m_nxt;
      shout_r <= shout_nxt;
      valid_r <= valid_nxt;
      neg_r   <= neg_nxt;
      d_r     <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ad_r  <= ad_nxt;
    t_r   <= t_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
  end

  assign magic_o              = m_r;
  assign shift_o              = shout_r;
  assign status_o.busy        = (state_r != M_IDLE);
  assign status_o.magic_valid = valid_r;
  assign status_o.div_neg     = neg_r;

  a_write_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wen |=> state_r == M_ABS)
    else $error("divisor write did not start magic computation");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == M_DONE && !cfg_wen) |=> state_r == M_IDLE && valid_r)
    else $error("magic completion did not return to idle");

  a_magic_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == M_IDLE && !cfg_wen) |=> $stable(m_r) && $stable(shout_r))
    else $error("magic changed while idle");

endmodule

FILE: rtl/core/sdim_quot.sv
// quotient datapath: multiply by magic, add, shift and sign fix-up
module sdim_quot import sdim_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [DATA_WIDTH-1:0] magic_i,
  input  logic [SHIFT_W-1:0]    shift_i,
  input  sdim_status_t          status_i,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,
  output logic                  out_tuser
);

  localparam int W = DATA_WIDTH;

  localparam logic [1:0] Q_IDLE = 2'd0;
  localparam logic [1:0] Q_MUL  = 2'd1;
  localparam logic [1:0] Q_FIN  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [W-1:0]         n_r;
  logic signed [2*W-1:0] prod_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [W-1:0]         out_q_r;
  logic                 out_dbz_r;

  logic                 out_free;
  logic                 accept;
  logic                 load_out;
  logic signed [W:0]    x1;
  logic signed [W:0]    x2;
  logic [W-1:0]         de;
  logic [W-1:0]         q_calc;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !status_i.busy &&
                     (state_r == Q_IDLE || (state_r == Q_FIN && out_free));
  assign accept    = in_tvalid && in_tready;
  assign load_out  = (state_r == Q_FIN) && out_free;

  // high half of m*n plus n, arithmetic post-shift, then sign correction
  assign x1     = (W+1)'($signed(prod_r[2*W-1:W])) + (W+1)'($signed(n_r));
  assign x2     = x1 >>> shift_i;
  assign de     = {W{status_i.div_neg}} + {{(W-1){1'b0}}, n_r[W-1]};
  assign q_calc = (x2[W-1:0] + de) ^ {W{status_i.div_neg}};

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      Q_IDLE: begin
        if (accept) begin
          state_nxt = Q_MUL;
        end
      end
      Q_MUL: state_nxt = Q_FIN;
      Q_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = accept ? Q_MUL : Q_IDLE;
        end
      end
      default: state_nxt = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= Q_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n_r <= in_tdata[W-1:0];
    end
    if (state_r == Q_MUL) begin
      prod_r <= $signed(magic_i) * $signed(n_r);
    end
    if (load_out) begin
      out_q_r   <= status_i.magic_valid ? q_calc : '0;
      out_dbz_r <= !status_i.magic_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'($signed(out_q_r));
  assign out_tuser  = out_dbz_r;

  a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == Q_MUL)
    else $error("accepted transaction did not enter multiply");

  a_mul_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == Q_MUL |=> state_r == Q_FIN)
    else $error("multiply step not followed by finish");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_tvalid)
    else $error("finished quotient not presented");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    status_i.busy |-> !in_tready)
    else $error("input taken while magic computation runs");

endmodule

FILE: rtl/core/signed_divide_by_invariant_magic_core.sv
// top level of the signed divide-by-invariant-divisor block
//
// Divides each signed dividend on the in_ stream by the divisor held in the
// configuration register, giving the quotient truncated toward zero on the
// out_ stream. A divisor of zero gives quotient 0 with out_tuser set.
// Writing cfg_wdata with cfg_wen high loads a new divisor and starts the
// magic computation: for a divisor other than 0 or +-1, a one-bit-a-cycle
// shift search for the post shift sh (up to DATA_WIDTH-2) and a restoring
// divide loop. in_tready stays low while it runs. Each dividend then goes
// through the registered multiplier and the add/shift/fix-up stage into the
// output register; a new dividend is taken only while the datapath is idle
// or as the previous result is loaded into the output register. While the
// receiver stalls, the finished result holds in the output register; one
// more dividend may be taken and multiplied, then in_tready drops until the
// output frees up.
// Reset (rst_n low at a clock edge) sets divisor 1, with its magic ready,
// and empties the output.
module signed_divide_by_invariant_magic_core import sdim_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wen,
  input  logic [TDATA_W-1:0] cfg_wdata,   // divisor
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,    // dividend
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,   // quotient
  output logic               out_tuser    // divide_by_zero
);

  logic [DATA_WIDTH-1:0] magic;
  logic [SHIFT_W-1:0]    post_shift;
  sdim_status_t          status;

  sdim_magic #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_magic (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .magic_o   (magic),
    .shift_o   (post_shift),
    .status_o  (status)
  );

  sdim_quot #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_quot (
    .clk        (clk),
    .rst_n      (rst_n),
    .magic_i    (magic),
    .shift_i    (post_shift),
    .status_i   (status),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: bench/tb_signed_divide_by_invariant_magic_core.sv
// testbench for the signed divide-by-invariant-divisor core: streams dividends, checks quotients
module tb_signed_divide_by_invariant_magic_core import sdim_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [31:0] INT_MIN     = 32'h8000_0000;
  localparam logic [31:0] INT_MAX     = 32'h7fff_ffff;

  typedef struct {
    logic [TDATA_W-1:0] dividend;
    logic [TDATA_W-1:0] quotient;
    logic               divide_by_zero;
  } quotient_result_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_wen    = 1'b0;
  logic [TDATA_W-1:0] cfg_wdata  = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;

  // divider state as the block should hold it
  logic [31:0] divisor_now = 32'd1;
  logic [31:0] magic_m     = 32'd1;
  logic [4:0]  magic_sh    = 5'd0;
  logic        magic_ok    = 1'b1;

  logic [TDATA_W-1:0] dividend_q[$];
  quotient_result_t   quotient_q[$];
  int                 in_flight   = 0;
  int                 mismatches  = 0;
  int                 cycle_count = 0;
  int                 in_wait     = 0;
  int                 out_wait    = 0;
  bit                 in_burst    = 0;
  bit                 out_burst   = 0;

  signed_divide_by_invariant_magic_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("signed_divide_by_invariant_magic_core verification failed");
      $finish;
    end
  end

  // shift and multiplier as worked out after a divisor write
  function automatic void load_divisor(logic [31:0] d);
    longint          sd;
    longint unsigned ad, t, q;
    int unsigned     sh;
    divisor_now = d;
    if (d == 32'd0) begin
      magic_ok = 1'b0;
      magic_m  = '0;
      magic_sh = '0;
      return;
    end
    sd = $signed(d);
    ad = (sd < 0) ? -sd : sd;
    t  = ad - 1;
    sh = 0;
    while (sh < 62 && (t >> (sh + 1)) != 0) sh++;
    q        = (64'd1 << (32 + sh)) / ad;
    magic_m  = 32'(q - (64'd1 << 32) + 64'd1);
    magic_sh = 5'(sh);
    magic_ok = 1'b1;
  endfunction

  function automatic quotient_result_t divide_by_magic(logic [31:0] dividend);
    quotient_result_t r;
    longint           n, m, sm, de, x;
    r.dividend = dividend;
    if (!magic_ok) begin
      r.quotient       = '0;
      r.divide_by_zero = 1'b1;
      return r;
    end
    n  = $signed(dividend);
    m  = $signed(magic_m);
    sm = divisor_now[31] ? -64'sd1 : 64'sd0;
    de = ((n < 0) ? 64'sd1 : 64'sd0) + sm;
    x  = ((m * n) >>> 32) + n;
    x  = (x >>> magic_sh) + de;
    x  = x ^ sm;
    r.quotient       = x[31:0];
    r.divide_by_zero = 1'b0;
    return r;
  endfunction

  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 5);
  endfunction

  // dividend driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) quotient_q.push_back(divide_by_magic(in_tdata));
      if (!(in_tvalid && !in_tready)) begin
        if (in_wait > 0) begin
          in_wait--;
          in_tvalid <= 1'b0;
        end else if (dividend_q.size() != 0) begin
          in_tdata  <= dividend_q.pop_front();
          in_tvalid <= 1'b1;
          in_wait = draw_gap(in_burst);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // quotient monitor
  always @(posedge clk) begin : result_monitor
    quotient_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (quotient_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected quotient transaction: %h dbz %b", out_tdata, out_tuser);
        end else begin
          want = quotient_q.pop_front();
          in_flight--;
          if (out_tdata !== want.quotient || out_tuser !== want.divide_by_zero) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: %h / %h expected %h dbz %b, got %h dbz %b",
                       want.dividend, divisor_now, want.quotient, want.divide_by_zero,
                       out_tdata, out_tuser);
          end
        end
        out_wait = draw_gap(out_burst);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_dividend(logic [31:0] n);
    dividend_q.push_back(n);
    in_flight++;
  endtask

  task automatic wait_idle();
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_divisor(logic [31:0] d);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_wen <= 1'b0;
    load_divisor(d);
  endtask

  function automatic logic [31:0] pick_divisor();
    int unsigned p;
    logic [31:0] v;
    p = $urandom_range(0, 30);
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0:       v = INT_MIN;
          1:       v = INT_MAX;
          2:       v = INT_MIN + 1;
          3:       v = 32'd1;
          4:       v = 32'hffff_ffff;
          default: v = 32'd0;
        endcase
      end
      1:       v = 32'd1 << p;
      2:       v = (32'd1 << p) + 32'($urandom_range(0, 2)) - 32'd1;
      3:       v = 32'($urandom_range(1, 40));
      4:       v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic logic [31:0] pick_dividend(logic [31:0] d);
    logic [31:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3:       return 32'($urandom_range(0, 600)) - 32'd300;
      4: begin
        case ($urandom_range(0, 3))
          0:       return INT_MIN;
          1:       return INT_MAX;
          2:       return INT_MIN + 1;
          default: return 32'hffff_ffff;
        endcase
      end
      default: begin
        // land on or right beside a multiple of the divisor
        k = $signed($urandom) >>> $urandom_range(0, 31);
        return k * d + 32'($urandom_range(0, 2)) - 32'd1;
      end
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] edge_vals[6];
    logic [31:0] d;
    int          count;
    edge_vals = '{INT_MIN, INT_MAX, 32'd0, 32'd1, 32'hffff_ffff, INT_MIN + 1};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // divisor one straight out of reset
    push_dividend(INT_MIN);
    push_dividend(INT_MAX);
    push_dividend(32'hffff_ffff);

    // minus one wraps the most negative dividend
    write_divisor(32'hffff_ffff);
    foreach (edge_vals[i]) push_dividend(edge_vals[i]);
    write_divisor(INT_MIN);
    foreach (edge_vals[i]) push_dividend(edge_vals[i]);
    write_divisor(32'd0);
    push_dividend(INT_MAX);
    push_dividend(32'd5);
    write_divisor(32'd1);
    push_dividend(INT_MIN);
    push_dividend(32'd0);
    write_divisor(32'd7);
    push_dividend(32'd14);
    push_dividend(32'hffff_fff2);
    push_dividend(32'd13);

    write_divisor(INT_MAX);
    for (int i = 0; i < 20; i++) push_dividend(pick_dividend(INT_MAX));

    for (int ph = 0; ph < 34; ph++) begin
      d = pick_divisor();
      write_divisor(d);
      count = (d == 32'd0) ? 4 : 20;
      for (int i = 0; i < count; i++) push_dividend(pick_dividend(d));
    end

    while (in_flight != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("signed_divide_by_invariant_magic_core verification clean");
    end else begin
      $display("signed_divide_by_invariant_magic_core verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sdim_pkg.sv
rtl/core/sdim_magic.sv
rtl/core/sdim_quot.sv
rtl/core/signed_divide_by_invariant_magic_core.sv
bench/tb_signed_divide_by_invariant_magic_core.sv
